// File: hdl/qlbd_pkg.sv
`timescale 1ns / 1ps

package qlbd_pkg;

	localparam int QN_W       = 24;
	localparam int WORK_W     = 16;
	localparam int WORK_SHIFT = 4;
	localparam int AMT_W      = WORK_W + WORK_SHIFT;
	localparam int IDX_OUT_W  = 4;
	localparam int SRV_W      = 5;
	localparam int POL_W      = 3;
	localparam int THR_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int LEH_W      = 64;
	localparam int HALF_W     = 32;
	localparam int SH_W       = 6;
	localparam int DIGIT_W    = 4;
	localparam int MOD_STEPS  = LEH_W / DIGIT_W;
	localparam int STEP_W     = $clog2(MOD_STEPS);

	localparam logic [LEH_W-1:0]  LEHMER_SEED   = 64'h60be_e2be_e120_fc15;
	localparam logic [HALF_W-1:0] LEHMER_MULT   = 32'he4dd_58b5;
	localparam logic [WORK_W-1:0] MARKER        = 16'hffff;
	localparam logic [SRV_W-1:0]  ACTIVE_RESET  = 5'd4;
	localparam logic [SH_W-1:0]   DRAW_SH_BASE  = 6'd32;

	localparam logic [POL_W-1:0] POL_RANDOM = 3'd1;
	localparam logic [POL_W-1:0] POL_RR     = 3'd2;
	localparam logic [POL_W-1:0] POL_JSQ    = 3'd3;
	localparam logic [POL_W-1:0] POL_JLW    = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY,
		CFG_BASE,
		CFG_ACTIVE,
		CFG_THREAD
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BOP_NONE,
		BOP_CLEAR,
		BOP_INC,
		BOP_DEC
	} bank_op_t;

	typedef struct packed {
		logic              command;
		logic [WORK_W-1:0] work_field;
		logic [QN_W-1:0]   return_queue_number;
	} in_item_t;

	typedef struct packed {
		logic [QN_W-1:0]      dest_queue_number;
		logic [IDX_OUT_W-1:0] chosen_index;
		logic                 status;
	} out_item_t;

endpackage

// File: hdl/qlbd_mod_unit.sv
`timescale 1ns / 1ps

module qlbd_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qlbd_pkg::LEH_W-1:0]  dividend,
	input  logic [qlbd_pkg::SRV_W-1:0]  divisor,
	output logic                        done,
	output logic [qlbd_pkg::SRV_W-1:0]  remainder
);
	import qlbd_pkg::*;

	localparam int PART_W = SRV_W + DIGIT_W;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [LEH_W-1:0]  sh_q;
	logic [SRV_W-1:0]  rem_q;
	logic [SRV_W-1:0]  div_q;
	logic [PART_W-1:0] part;

	// one digit per cycle: reduce {rem, digit} below the divisor
	always_comb begin
		logic [PART_W-1:0] nk;
		part = {rem_q, sh_q[LEH_W-1 -: DIGIT_W]};
		for (int k = DIGIT_W - 1; k >= 0; k--) begin
			nk = PART_W'(div_q) << k;
			if (part >= nk) begin
				part = part - nk;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				sh_q  <= dividend;
				rem_q <= '0;
				div_q <= divisor;
			end else if (run_q) begin
				rem_q <= part[SRV_W-1:0];
				sh_q  <= sh_q << DIGIT_W;
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(MOD_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: hdl/qlbd_load_bank.sv
`timescale 1ns / 1ps

module qlbd_load_bank #(
	parameter int MAX_SERVERS   = 16,
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qlbd_pkg::bank_op_t                  op,
	input  logic [qlbd_pkg::SRV_W-1:0]          servers,
	input  logic [$clog2(MAX_SERVERS)-1:0]      index,
	input  logic [qlbd_pkg::AMT_W-1:0]          amount,
	output logic                                done,
	output logic [$clog2(MAX_SERVERS)-1:0]      win_index
);
	import qlbd_pkg::*;

	localparam int IDX_W = $clog2(MAX_SERVERS);
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN,
		B_INC_WR,
		B_DEC_RD,
		B_DEC_WR
	} bstate_t;

	bstate_t                  bstate_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [SRV_W-1:0]         n_q;
	logic [AMT_W-1:0]         amt_q;
	logic [COUNTER_WIDTH-1:0] best_v_q;
	logic [IDX_W-1:0]         best_i_q;
	logic                     done_q;
	logic [MAX_SERVERS-1:0]   valid_q;
	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     rd_hit_s1;
	logic [COUNTER_WIDTH-1:0] rd_data_s1;

	logic [COUNTER_WIDTH-1:0] mem [MAX_SERVERS];

	logic                     issue;
	logic                     take_new;
	logic [IDX_W-1:0]         rd_addr;
	logic [COUNTER_WIDTH-1:0] rd_val;
	logic                     wr_en;
	logic [COUNTER_WIDTH-1:0] wr_data;

	assign issue    = (bstate_q == B_SCAN) && (cnt_q != CNT_W'(n_q));
	assign rd_addr  = (bstate_q == B_SCAN) ? cnt_q[IDX_W-1:0] : best_i_q;
	assign rd_val   = rd_hit_s1 ? rd_data_s1 : '0;
	assign take_new = vld_s1 && ((idx_s1 == '0) || (rd_val < best_v_q));
	assign wr_en    = (bstate_q == B_INC_WR) || (bstate_q == B_DEC_WR);
	assign wr_data  = (bstate_q == B_INC_WR) ? best_v_q + COUNTER_WIDTH'(amt_q)
	                                         : rd_val - COUNTER_WIDTH'(amt_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[best_i_q] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q  <= B_IDLE;
			cnt_q     <= '0;
			n_q       <= '0;
			amt_q     <= '0;
			best_v_q  <= '0;
			best_i_q  <= '0;
			done_q    <= 1'b0;
			valid_q   <= '0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			rd_hit_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			vld_s1    <= issue;
			idx_s1    <= cnt_q[IDX_W-1:0];
			rd_hit_s1 <= valid_q[rd_addr];
			unique case (bstate_q)
				B_IDLE: begin
					unique case (op)
						BOP_NONE: begin
						end
						BOP_CLEAR: begin
							valid_q <= '0;
						end
						BOP_INC: begin
							cnt_q    <= '0;
							n_q      <= servers;
							amt_q    <= amount;
							bstate_q <= B_SCAN;
						end
						BOP_DEC: begin
							best_i_q <= index;
							amt_q    <= amount;
							bstate_q <= B_DEC_RD;
						end
						default: begin
						end
					endcase
				end
				B_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (take_new) begin
						best_v_q <= rd_val;
						best_i_q <= idx_s1;
					end
					if (vld_s1 && !issue) begin
						bstate_q <= B_INC_WR;
					end
				end
				B_INC_WR: begin
					valid_q[best_i_q] <= 1'b1;
					done_q            <= 1'b1;
					bstate_q          <= B_IDLE;
				end
				B_DEC_RD: begin
					bstate_q <= B_DEC_WR;
				end
				B_DEC_WR: begin
					valid_q[best_i_q] <= 1'b1;
					done_q            <= 1'b1;
					bstate_q          <= B_IDLE;
				end
				default: begin
					bstate_q <= B_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign win_index = best_i_q;

endmodule

// File: hdl/queue_load_balancer_dispatch_unit.sv
// path to the strobe: decode only for a reset marker or a completion that leaves counters alone,
// a counter read and write for a counted completion, the round-robin step for round robin, a
// scan for shortest queue / least work (one counter read per cycle over n servers), the 4-bit
// digit remainder unit for fixed offset and first round robin, generator step first for random
// one item at a time: busy drops with the strobe, the next start is taken at the edge ending it
// arst_n clears registers, counters, round-robin state and reloads the random seed
`timescale 1ns / 1ps

module queue_load_balancer_dispatch_unit #(
	parameter int MAX_SERVERS   = 16,
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [qlbd_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [qlbd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  qlbd_pkg::in_item_t                 item,
	output logic                               result_valid,
	output qlbd_pkg::out_item_t                result
);
	import qlbd_pkg::*;

	localparam int IDX_W = $clog2(MAX_SERVERS);
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADV,
		ST_DRAW,
		ST_MOD,
		ST_RR,
		ST_BANK
	} state_t;

	state_t             state_q;
	logic [POL_W-1:0]   policy_q;
	logic [QN_W-1:0]    base_q;
	logic [SRV_W-1:0]   active_q;
	logic [THR_W-1:0]   thread_q;
	logic [IDX_W-1:0]   rr_pos_q;
	logic               rr_loaded_q;
	logic               rr_load_q;
	logic [LEH_W-1:0]   lehmer_q;
	logic [LEH_W-1:0]   plo_q;
	logic [HALF_W-1:0]  phi_q;
	in_item_t           item_q;
	logic [SRV_W-1:0]   n_q;
	logic               result_valid_q;
	out_item_t          result_q;

	logic [SRV_W-1:0]   servers;
	logic               is_marker;
	logic               pol_ld;
	logic [QN_W-1:0]    eg_diff;
	logic               eg_in;
	logic [AMT_W-1:0]   amt;
	logic [CNT_W-1:0]   rr_inc;
	logic [IDX_W-1:0]   rr_nxt;
	logic [SH_W-1:0]    draw_sh;
	logic [HALF_W-1:0]  mul_a;
	logic [LEH_W-1:0]   mul_p;
	logic               mod_start;
	logic [LEH_W-1:0]   mod_dividend;
	logic               mod_done;
	logic [SRV_W-1:0]   mod_rem;
	bank_op_t           bank_op;
	logic               bank_done;
	logic [IDX_W-1:0]   bank_win;
	logic [IDX_W-1:0]   pick_idx;
	logic [QN_W-1:0]    ing_dest;

	always_comb begin
		if (active_q == '0) begin
			servers = SRV_W'(1);
		end else if (32'(active_q) > MAX_SERVERS) begin
			servers = SRV_W'(MAX_SERVERS);
		end else begin
			servers = active_q;
		end
	end

	assign is_marker = (item_q.work_field == MARKER);
	assign pol_ld    = (policy_q == POL_JSQ) || (policy_q == POL_JLW);
	assign eg_diff   = item_q.return_queue_number - base_q;
	assign eg_in     = (item_q.return_queue_number >= base_q) && (eg_diff < QN_W'(n_q));
	assign amt       = (policy_q == POL_JSQ) ? AMT_W'(1)
	                                         : {item_q.work_field, {WORK_SHIFT{1'b0}}};
	assign rr_inc    = CNT_W'(rr_pos_q) + CNT_W'(1);
	assign rr_nxt    = (rr_inc == CNT_W'(n_q)) ? '0 : rr_inc[IDX_W-1:0];
	assign draw_sh   = DRAW_SH_BASE - {1'b0, thread_q, 1'b0};

	// shared 32x32 multiplier, low half then high half of the generator state
	assign mul_a = (state_q == ST_MUL_LO) ? lehmer_q[HALF_W-1:0] : lehmer_q[LEH_W-1:HALF_W];
	assign mul_p = LEH_W'(mul_a) * LEH_W'(LEHMER_MULT);

	always_comb begin
		mod_start    = 1'b0;
		mod_dividend = LEH_W'(thread_q);
		bank_op      = BOP_NONE;
		if (state_q == ST_DECODE) begin
			if (is_marker) begin
				bank_op = BOP_CLEAR;
			end else if (item_q.command) begin
				if (eg_in && pol_ld) begin
					bank_op = BOP_DEC;
				end
			end else if (pol_ld) begin
				bank_op = BOP_INC;
			end else if ((policy_q != POL_RANDOM) && !(policy_q == POL_RR && rr_loaded_q)) begin
				mod_start = 1'b1;
			end
		end else if (state_q == ST_DRAW) begin
			mod_start    = 1'b1;
			mod_dividend = lehmer_q >> draw_sh;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_MOD:  pick_idx = IDX_W'(mod_rem);
			ST_RR:   pick_idx = rr_nxt;
			ST_BANK: pick_idx = bank_win;
			default: pick_idx = '0;
		endcase
	end

	assign ing_dest = base_q + QN_W'(pick_idx);

	qlbd_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_dividend),
		.divisor   (n_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	qlbd_load_bank #(
		.MAX_SERVERS   (MAX_SERVERS),
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (bank_op),
		.servers   (n_q),
		.index     (eg_diff[IDX_W-1:0]),
		.amount    (amt),
		.done      (bank_done),
		.win_index (bank_win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			policy_q       <= '0;
			base_q         <= '0;
			active_q       <= ACTIVE_RESET;
			thread_q       <= '0;
			rr_pos_q       <= '0;
			rr_loaded_q    <= 1'b0;
			rr_load_q      <= 1'b0;
			lehmer_q       <= LEHMER_SEED;
			plo_q          <= '0;
			phi_q          <= '0;
			item_q         <= '0;
			n_q            <= SRV_W'(1);
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_addr))
					CFG_POLICY: policy_q <= cfg_wdata[POL_W-1:0];
					CFG_BASE:   base_q   <= cfg_wdata[QN_W-1:0];
					CFG_ACTIVE: begin
						active_q    <= cfg_wdata[SRV_W-1:0];
						rr_loaded_q <= 1'b0;
					end
					CFG_THREAD: begin
						thread_q    <= cfg_wdata[THR_W-1:0];
						rr_loaded_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q  <= item;
						n_q     <= servers;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (is_marker) begin
						result_valid_q <= 1'b1;
						result_q       <= '{
							dest_queue_number: item_q.command ? item_q.return_queue_number
							                                  : base_q,
							chosen_index: '0,
							status: 1'b0};
						state_q        <= ST_IDLE;
					end else if (item_q.command) begin
						if (!eg_in) begin
							result_valid_q <= 1'b1;
							result_q       <= '{
								dest_queue_number: item_q.return_queue_number,
								chosen_index: '0,
								status: 1'b1};
							state_q        <= ST_IDLE;
						end else if (pol_ld) begin
							state_q <= ST_BANK;
						end else begin
							result_valid_q <= 1'b1;
							result_q       <= '{
								dest_queue_number: item_q.return_queue_number,
								chosen_index: eg_diff[IDX_OUT_W-1:0],
								status: 1'b0};
							state_q        <= ST_IDLE;
						end
					end else begin
						case (policy_q) inside
							POL_RANDOM: begin
								state_q <= ST_MUL_LO;
							end
							POL_RR: begin
								if (rr_loaded_q) begin
									state_q <= ST_RR;
								end else begin
									rr_load_q <= 1'b1;
									state_q   <= ST_MOD;
								end
							end
							POL_JSQ, POL_JLW: begin
								state_q <= ST_BANK;
							end
							default: begin
								rr_load_q <= 1'b0;
								state_q   <= ST_MOD;
							end
						endcase
					end
				end
				ST_MUL_LO: begin
					plo_q   <= mul_p;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					phi_q   <= mul_p[HALF_W-1:0];
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					lehmer_q <= plo_q + {phi_q, {HALF_W{1'b0}}};
					state_q  <= ST_DRAW;
				end
				ST_DRAW: begin
					rr_load_q <= 1'b0;
					state_q   <= ST_MOD;
				end
				ST_MOD: begin
					if (mod_done) begin
						if (rr_load_q) begin
							rr_pos_q    <= IDX_W'(mod_rem);
							rr_loaded_q <= 1'b1;
							state_q     <= ST_RR;
						end else begin
							result_valid_q <= 1'b1;
							result_q       <= '{
								dest_queue_number: ing_dest,
								chosen_index: IDX_OUT_W'(pick_idx),
								status: 1'b0};
							state_q        <= ST_IDLE;
						end
					end
				end
				ST_RR: begin
					rr_pos_q       <= rr_nxt;
					result_valid_q <= 1'b1;
					result_q       <= '{
						dest_queue_number: ing_dest,
						chosen_index: IDX_OUT_W'(pick_idx),
						status: 1'b0};
					state_q        <= ST_IDLE;
				end
				ST_BANK: begin
					if (bank_done) begin
						result_valid_q <= 1'b1;
						result_q       <= '{
							dest_queue_number: item_q.command ? item_q.return_queue_number
							                                  : ing_dest,
							chosen_index: IDX_OUT_W'(pick_idx),
							status: 1'b0};
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one beat");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while sequencer still busy");

	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rr_loaded_q |-> (CNT_W'(rr_pos_q) < CNT_W'(servers)))
		else $error("round-robin position outside server range");

endmodule

// File: sim/tb_queue_load_balancer_dispatch_unit.sv
`timescale 1ns / 1ps

module tb_queue_load_balancer_dispatch_unit;

	import qlbd_pkg::*;

	localparam int MAX_SRV      = 16;
	localparam int CTR_W        = 32;
	localparam int RANDOM_ITEMS = 480;
	localparam int TAIL_CYCLES  = 30;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [POL_W-1:0] POL_FIXED    = 3'd0;
	localparam logic [POL_W-1:0] POL_UNDEF_LO = 3'd5;
	localparam logic [POL_W-1:0] POL_UNDEF_HI = 3'd7;
	localparam logic             CMD_INGRESS  = 1'b0;
	localparam logic             CMD_EGRESS   = 1'b1;
	localparam logic             STATUS_OK    = 1'b0;
	localparam logic             STATUS_RANGE = 1'b1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  start = 1'b0;
	logic                  busy;
	in_item_t              item = '0;
	logic                  result_valid;
	out_item_t             result;

	// predictor state
	logic [CTR_W-1:0]  load_ctr [MAX_SRV];
	logic [3:0]        rr_pos;
	bit                rr_armed;
	logic [LEH_W-1:0]  lcg_state;
	logic [POL_W-1:0]  cur_policy;
	logic [QN_W-1:0]   cur_base;
	logic [SRV_W-1:0]  cur_active;
	logic [THR_W-1:0]  cur_thread;

	out_item_t   pending_dispatch [$];
	out_item_t   want;
	bit          failed = 1'b0;
	bit          sender_idles = 1'b1;
	int unsigned cycle_count = 0;

	queue_load_balancer_dispatch_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_dispatch.size() == 0) begin
				$error("result beat with nothing pending: %p", result);
				failed = 1'b1;
			end else begin
				want = pending_dispatch.pop_front();
				if (result.dest_queue_number !== want.dest_queue_number) begin
					$error("dest_queue_number: expected %h, got %h",
						want.dest_queue_number, result.dest_queue_number);
					failed = 1'b1;
				end
				if (result.chosen_index !== want.chosen_index) begin
					$error("chosen_index: expected %0d, got %0d",
						want.chosen_index, result.chosen_index);
					failed = 1'b1;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic int unsigned servers_used();
		if (cur_active == 0)
			return 1;
		if (cur_active > MAX_SRV)
			return MAX_SRV;
		return cur_active;
	endfunction

	function automatic out_item_t dispatch_predict(in_item_t it);
		out_item_t   r;
		int unsigned n;
		int unsigned idx;
		logic [63:0] draw;
		logic [CTR_W-1:0] amount;
		n = servers_used();
		amount = CTR_W'(it.work_field) << WORK_SHIFT;
		idx = 0;
		r.status = STATUS_OK;
		if (it.work_field == MARKER) begin
			foreach (load_ctr[i])
				load_ctr[i] = '0;
			r.dest_queue_number = (it.command == CMD_INGRESS) ? cur_base : it.return_queue_number;
		end else if (it.command == CMD_INGRESS) begin
			case (cur_policy)
				POL_RANDOM: begin
					lcg_state = lcg_state * LEH_W'(LEHMER_MULT);
					draw = lcg_state >> (32 - 2 * int'(cur_thread));
					idx = 32'(draw % 64'(n));
				end
				POL_RR: begin
					if (!rr_armed) begin
						rr_pos = 4'(cur_thread % n);
						rr_armed = 1'b1;
					end
					rr_pos = 4'((rr_pos + 1) % n);
					idx = rr_pos;
				end
				POL_JSQ, POL_JLW: begin
					for (int i = 1; i < n; i++)
						if (load_ctr[i] < load_ctr[idx])
							idx = i;
					load_ctr[idx] = load_ctr[idx] + ((cur_policy == POL_JSQ) ? CTR_W'(1) : amount);
				end
				default: begin
					idx = cur_thread % n;
				end
			endcase
			r.dest_queue_number = QN_W'(cur_base + idx);
		end else begin
			r.dest_queue_number = it.return_queue_number;
			if (it.return_queue_number >= cur_base && (it.return_queue_number - cur_base) < n) begin
				idx = it.return_queue_number - cur_base;
				if (cur_policy == POL_JSQ)
					load_ctr[idx] = load_ctr[idx] - CTR_W'(1);
				else if (cur_policy == POL_JLW)
					load_ctr[idx] = load_ctr[idx] - amount;
			end else begin
				r.status = STATUS_RANGE;
			end
		end
		r.chosen_index = IDX_OUT_W'(idx);
		return r;
	endfunction

	function automatic in_item_t beat_of(logic cmd, logic [WORK_W-1:0] work, logic [QN_W-1:0] q);
		in_item_t it;
		it.command = cmd;
		it.work_field = work;
		it.return_queue_number = q;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t    it;
		int unsigned n;
		int unsigned roll;
		n = servers_used();
		it.command = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < 4)
			it.work_field = MARKER;
		else if (roll < 8)
			it.work_field = '0;
		else if (roll < 12)
			it.work_field = MARKER - WORK_W'(1);
		else
			it.work_field = WORK_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 70)
			it.return_queue_number = QN_W'(cur_base + $urandom_range(0, n - 1));
		else if (roll < 80)
			it.return_queue_number = QN_W'(cur_base + n);
		else if (roll < 88)
			it.return_queue_number = QN_W'(cur_base - 1);
		else
			it.return_queue_number = QN_W'($urandom);
		return it;
	endfunction

	task automatic reset_model();
		foreach (load_ctr[i])
			load_ctr[i] = '0;
		rr_pos = '0;
		rr_armed = 1'b0;
		lcg_state = LEHMER_SEED;
		cur_policy = POL_FIXED;
		cur_base = '0;
		cur_active = ACTIVE_RESET;
		cur_thread = '0;
	endtask

	// write enable is left high; callers lower it after their last write
	task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= which;
		cfg_wdata <= data;
		@(posedge clk);
		case (which)
			CFG_POLICY: cur_policy = data[POL_W-1:0];
			CFG_BASE:   cur_base = data[QN_W-1:0];
			CFG_ACTIVE: begin
				cur_active = data[SRV_W-1:0];
				rr_armed = 1'b0;
			end
			CFG_THREAD: begin
				cur_thread = data[THR_W-1:0];
				rr_armed = 1'b0;
			end
		endcase
	endtask

	task automatic program_regs(logic [POL_W-1:0] pol, logic [QN_W-1:0] base,
			logic [SRV_W-1:0] act, logic [THR_W-1:0] thr);
		write_reg(CFG_POLICY, CFG_DATA_W'(pol));
		write_reg(CFG_BASE, base);
		write_reg(CFG_ACTIVE, CFG_DATA_W'(act));
		write_reg(CFG_THREAD, CFG_DATA_W'(thr));
		cfg_wr_en <= 1'b0;
	endtask

	// start stays high after a beat so back-to-back items need no toggle
	task automatic send_beat(in_item_t it);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_dispatch.insert(pending_dispatch.size(), dispatch_predict(it));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_dispatch.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_beat(beat_of(CMD_INGRESS, 16'h1234, 24'h000000));
		send_beat(beat_of(CMD_EGRESS, 16'h0001, 24'h000003));
		send_beat(beat_of(CMD_EGRESS, 16'h0001, 24'h000004));
	endtask

	task automatic test_markers();
		send_beat(beat_of(CMD_INGRESS, MARKER, 24'h123456));
		send_beat(beat_of(CMD_EGRESS, MARKER, 24'hffffff));
	endtask

	task automatic test_policies();
		drain();
		program_regs(POL_FIXED, 24'hfffffe, 5'd16, 4'd15);
		send_beat(beat_of(CMD_INGRESS, 16'h0000, 24'h000000));
		drain();
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_RR));
		cfg_wr_en <= 1'b0;
		repeat (3) send_beat(beat_of(CMD_INGRESS, 16'h0010, 24'h000000));
		drain();
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_RANDOM));
		cfg_wr_en <= 1'b0;
		repeat (2) send_beat(beat_of(CMD_INGRESS, 16'h0020, 24'h000000));
		drain();
		program_regs(POL_JSQ, 24'h000100, 5'd4, 4'd0);
		repeat (2) send_beat(beat_of(CMD_INGRESS, 16'h0005, 24'h000000));
		send_beat(beat_of(CMD_EGRESS, 16'h0005, 24'h000100));
		drain();
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_JLW));
		cfg_wr_en <= 1'b0;
		send_beat(beat_of(CMD_INGRESS, 16'hfffe, 24'h000000));
		send_beat(beat_of(CMD_EGRESS, 16'h0003, 24'h000101));
	endtask

	task automatic test_counter_wrap();
		drain();
		program_regs(POL_JSQ, 24'h000000, 5'd1, 4'd0);
		send_beat(beat_of(CMD_EGRESS, 16'h0001, 24'h000000));
		send_beat(beat_of(CMD_INGRESS, 16'h0001, 24'h000000));
		drain();
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_JLW));
		cfg_wr_en <= 1'b0;
		send_beat(beat_of(CMD_EGRESS, 16'hfffe, 24'h000000));
		send_beat(beat_of(CMD_INGRESS, 16'hfffe, 24'h000000));
		send_beat(beat_of(CMD_INGRESS, 16'h0000, 24'h000000));
	endtask

	task automatic test_odd_config();
		drain();
		program_regs(POL_UNDEF_HI, 24'h000010, 5'd0, 4'd9);
		send_beat(beat_of(CMD_INGRESS, 16'h0007, 24'h000000));
		send_beat(beat_of(CMD_EGRESS, 16'h0007, 24'h000011));
		drain();
		program_regs(POL_UNDEF_LO, 24'h000010, 5'd31, 4'd9);
		send_beat(beat_of(CMD_INGRESS, 16'h0007, 24'h000000));
		send_beat(beat_of(CMD_EGRESS, 16'h0007, 24'h00001f));
	endtask

	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned len;
		int unsigned roll;
		logic [POL_W-1:0] pol;
		logic [QN_W-1:0]  base;
		logic [SRV_W-1:0] act;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			pol = ($urandom_range(0, 99) < 85) ? POL_W'($urandom_range(0, 4))
			                                   : POL_W'($urandom_range(5, 7));
			write_reg(CFG_POLICY, {21'($urandom), pol});
			if ($urandom_range(0, 3) != 0) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					base = '0;
				else if (roll == 1)
					base = 24'hffffff;
				else if (roll == 2)
					base = 24'hfffff8;
				else
					base = QN_W'($urandom);
				write_reg(CFG_BASE, base);
			end
			if ($urandom_range(0, 3) != 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					act = 5'd0;
				else if (roll < 20)
					act = SRV_W'($urandom_range(17, 31));
				else if (roll < 30)
					act = 5'd16;
				else if (roll < 40)
					act = 5'd1;
				else
					act = SRV_W'($urandom_range(1, 16));
				write_reg(CFG_ACTIVE, {19'($urandom), act});
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_THREAD, {20'($urandom), 4'($urandom)});
			cfg_wr_en <= 1'b0;
			sender_idles = ($urandom_range(0, 2) != 0);
			len = $urandom_range(10, 60);
			repeat (len) begin
				send_beat(random_item());
				sent++;
			end
		end
	endtask

	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_markers();
		test_policies();
		test_counter_wrap();
		test_odd_config();
		test_random_traffic();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: queue_load_balancer_dispatch_unit.f
hdl/qlbd_pkg.sv
hdl/qlbd_mod_unit.sv
hdl/qlbd_load_bank.sv
hdl/queue_load_balancer_dispatch_unit.sv
sim/tb_queue_load_balancer_dispatch_unit.sv
